// ----- rtl/radix_digit_emitter_top_defines.svh -----
// Assertion macros shared by the radix digit emitter modules.
`ifndef RADIX_DIGIT_EMITTER_TOP_DEFINES_SVH
`define RADIX_DIGIT_EMITTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define RDE_CHECK(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("radix digit emitter check failed");

// Next-cycle implication, disabled while reset is held.
`define RDE_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("radix digit emitter check failed");

`endif

// ----- rtl/rde_pkg.sv -----
// Package with types, constants and helpers of the radix digit emitter.
package rde_pkg;

    // Value and field widths
    localparam int VALUE_WIDTH = 64;
    localparam int NUMBER_W    = 64;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 7;
    localparam int COUNT_W     = 7;

    // Digit store
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Division: STEP_BITS quotient bits per cycle
    localparam int STEP_BITS  = 8;
    localparam int DIV_CHUNKS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W      = DIV_CHUNKS * STEP_BITS;
    localparam int CHUNK_W    = $clog2(DIV_CHUNKS + 1);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    // Radix limits
    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    // ASCII anchors
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 4'd10;

    typedef struct packed {
        logic [NUMBER_W-1:0] number;
        logic [RADIX_W-1:0]  radix;
        logic                signed_mode;
        logic                upper_case;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0]  digit_char;
        logic               last_digit;
        logic [COUNT_W-1:0] digit_count;
    } t_out_item;

    // Normalized job handed from front to back
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] magnitude;
        logic [RADIX_W-1:0]     radix;
        logic                   upper;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_back_state;

    // Map a digit value to its ASCII code
    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d,
                                                      input logic upper);
        logic [CHAR_W-1:0] off;
        off = CHAR_W'(d - DIGIT_TEN);
        if (d < DIGIT_TEN) begin
            digit_ascii = CHAR_ZERO + CHAR_W'(d);
        end else if (upper) begin
            digit_ascii = CHAR_UPPER_A + off;
        end else begin
            digit_ascii = CHAR_LOWER_A + off;
        end
    endfunction

endpackage

// ----- rtl/rde_front.sv -----
// Front end: accept items, normalize radix, sign and case, and queue them.
module rde_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  rde_pkg::t_in_item i_item,
    output rde_pkg::t_job     o_job,
    output logic              o_job_valid,
    input  logic              i_job_pop
);

    rde_pkg::t_job                    r_q [rde_pkg::QUEUE_DEPTH];
    logic [rde_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [rde_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [rde_pkg::FILL_W-1:0]       r_fill;
    logic [rde_pkg::FILL_W-1:0]       n_fill;
    logic                             push;
    logic [rde_pkg::VALUE_WIDTH-1:0]  value;
    rde_pkg::t_job                    job_in;

    // Classify the item: saturate radix, take magnitude, force upper case when signed
    always_comb begin
        value = i_item.number[rde_pkg::VALUE_WIDTH-1:0];
        job_in.upper = i_item.upper_case | i_item.signed_mode;
        if (i_item.signed_mode && value[rde_pkg::VALUE_WIDTH-1]) begin
            job_in.magnitude = ~value + rde_pkg::VALUE_WIDTH'(1);
        end else begin
            job_in.magnitude = value;
        end
        if (i_item.radix inside {[5'd0:5'd1]}) begin
            job_in.radix = rde_pkg::RADIX_MIN;
        end else if (i_item.radix > rde_pkg::RADIX_MAX) begin
            job_in.radix = rde_pkg::RADIX_MAX;
        end else begin
            job_in.radix = i_item.radix;
        end
    end

    assign o_stall     = (r_fill == rde_pkg::FILL_W'(rde_pkg::QUEUE_DEPTH));
    assign push        = i_valid && !o_stall;
    assign o_job_valid = (r_fill != '0);
    assign o_job       = r_q[r_rd_ptr];

    // Track queue occupancy
    always_comb begin
        n_fill = r_fill;
        if (push && !i_job_pop) begin
            n_fill = r_fill + rde_pkg::FILL_W'(1);
        end else if (!push && i_job_pop) begin
            n_fill = r_fill - rde_pkg::FILL_W'(1);
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_fill <= n_fill;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + rde_pkg::QPTR_W'(1);
            end
            if (i_job_pop) begin
                r_rd_ptr <= r_rd_ptr + rde_pkg::QPTR_W'(1);
            end
        end
    end

    // Hold queued jobs
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= job_in;
        end
    end

`include "radix_digit_emitter_top_defines.svh"

    `RDE_CHECK(a_fill_bound, 1'b1, r_fill <= rde_pkg::FILL_W'(rde_pkg::QUEUE_DEPTH))
    `RDE_CHECK(a_pop_nonempty, i_job_pop, r_fill != '0)
    `RDE_CHECK_NEXT(a_fill_inc, push && !i_job_pop, r_fill == $past(r_fill) + rde_pkg::FILL_W'(1))

endmodule

// ----- rtl/rde_back.sv -----
// Back end: divide the magnitude digit by digit, store digits, emit them in reverse.
module rde_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rde_pkg::t_job      i_job,
    input  logic               i_job_valid,
    output logic               o_job_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output rde_pkg::t_out_item o_item
);

    rde_pkg::t_back_state             r_state;
    rde_pkg::t_back_state             n_state;

    logic [rde_pkg::DIGIT_W-1:0]      r_store [rde_pkg::STORE_DEPTH];

    logic [rde_pkg::PAD_W-1:0]        r_val;
    logic [rde_pkg::RADIX_W-1:0]      r_radix;
    logic                             r_upper;
    logic [rde_pkg::DIGIT_W-1:0]      r_rem;
    logic [rde_pkg::CHUNK_W-1:0]      r_chunk;
    logic                             r_qnz;
    logic [rde_pkg::COUNT_W-1:0]      r_count;
    logic [rde_pkg::COUNT_W-1:0]      r_rd_left;
    logic                             r_rd_pend;
    logic [rde_pkg::DIGIT_W-1:0]      r_rd_data;
    logic                             r_rd_last;
    logic                             r_out_valid;
    rde_pkg::t_out_item               r_out;

    logic [rde_pkg::STEP_BITS-1:0]    chunk_in;
    logic [rde_pkg::DIGIT_W:0]        div_acc;
    logic [rde_pkg::DIGIT_W-1:0]      div_rem;
    logic [rde_pkg::STEP_BITS-1:0]    div_q;
    logic                             last_chunk;
    logic                             digit_done;
    logic                             finish_div;
    logic                             more_digits;
    logic                             rd_en;
    logic                             load;
    logic [rde_pkg::ADDR_W-1:0]       rd_addr;

    // Store address of the next digit to read
    function automatic logic [rde_pkg::ADDR_W-1:0] rd_addr_of(
        input logic [rde_pkg::COUNT_W-1:0] left);
        logic [rde_pkg::COUNT_W-1:0] idx;
        idx = left - rde_pkg::COUNT_W'(1);
        rd_addr_of = idx[rde_pkg::ADDR_W-1:0];
    endfunction

    // One division chunk: STEP_BITS restoring steps on the narrow remainder
    assign chunk_in = r_val[rde_pkg::PAD_W-1 -: rde_pkg::STEP_BITS];

    always_comb begin
        div_rem = r_rem;
        div_acc = '0;
        div_q   = '0;
        for (int i = 0; i < rde_pkg::STEP_BITS; i++) begin
            div_acc = {div_rem, chunk_in[rde_pkg::STEP_BITS-1-i]};
            if (div_acc >= r_radix) begin
                div_q[rde_pkg::STEP_BITS-1-i] = 1'b1;
                div_acc = div_acc - r_radix;
            end
            div_rem = div_acc[rde_pkg::DIGIT_W-1:0];
        end
    end

    assign last_chunk  = (r_chunk == rde_pkg::CHUNK_W'(rde_pkg::DIV_CHUNKS - 1));
    assign digit_done  = (r_state == rde_pkg::ST_DIV) && last_chunk;
    assign more_digits = (r_qnz || (div_q != '0))
                         && (r_count != rde_pkg::COUNT_W'(rde_pkg::STORE_DEPTH - 1));
    assign finish_div  = digit_done && !more_digits;
    assign rd_addr     = rd_addr_of(r_rd_left);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rde_pkg::ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = rde_pkg::ST_DIV;
                end
            end
            rde_pkg::ST_DIV: begin
                if (finish_div) begin
                    n_state = rde_pkg::ST_EMIT;
                end
            end
            rde_pkg::ST_EMIT: begin
                if ((r_rd_left == '0) && (!r_rd_pend || load)) begin
                    n_state = rde_pkg::ST_IDLE;
                end
            end
            default: n_state = rde_pkg::ST_IDLE;
        endcase
    end

    // State outputs: pop, store read, output load
    always_comb begin
        o_job_pop = 1'b0;
        rd_en     = 1'b0;
        load      = r_rd_pend && (!r_out_valid || !i_stall);
        case (r_state)
            rde_pkg::ST_IDLE: begin
                o_job_pop = i_job_valid;
            end
            rde_pkg::ST_EMIT: begin
                rd_en = (r_rd_left != '0) && (!r_rd_pend || load);
            end
            default: begin
                o_job_pop = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rde_pkg::ST_IDLE;
            r_count     <= '0;
            r_chunk     <= '0;
            r_qnz       <= 1'b0;
            r_rd_left   <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_job_pop) begin
                r_count <= '0;
                r_chunk <= '0;
                r_qnz   <= 1'b0;
            end else if (r_state == rde_pkg::ST_DIV) begin
                if (last_chunk) begin
                    r_chunk <= '0;
                    r_qnz   <= 1'b0;
                    r_count <= r_count + rde_pkg::COUNT_W'(1);
                end else begin
                    r_chunk <= r_chunk + rde_pkg::CHUNK_W'(1);
                    r_qnz   <= r_qnz | (div_q != '0);
                end
            end
            if (finish_div) begin
                r_rd_left <= r_count + rde_pkg::COUNT_W'(1);
            end else if (rd_en) begin
                r_rd_left <= r_rd_left - rde_pkg::COUNT_W'(1);
            end
            if (rd_en) begin
                r_rd_pend <= 1'b1;
            end else if (load) begin
                r_rd_pend <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers and digit store
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_val   <= rde_pkg::PAD_W'(i_job.magnitude);
            r_radix <= i_job.radix;
            r_upper <= i_job.upper;
            r_rem   <= '0;
        end else if (r_state == rde_pkg::ST_DIV) begin
            r_val <= (r_val << rde_pkg::STEP_BITS) | rde_pkg::PAD_W'(div_q);
            r_rem <= last_chunk ? '0 : div_rem;
        end
        if (digit_done) begin
            r_store[r_count[rde_pkg::ADDR_W-1:0]] <= div_rem;
        end
        if (rd_en) begin
            r_rd_data <= r_store[rd_addr];
            r_rd_last <= (r_rd_left == rde_pkg::COUNT_W'(1));
        end
        if (load) begin
            r_out.digit_char  <= rde_pkg::digit_ascii(r_rd_data, r_upper);
            r_out.last_digit  <= r_rd_last;
            r_out.digit_count <= r_rd_last ? r_count : '0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

`include "radix_digit_emitter_top_defines.svh"

    `RDE_CHECK(a_rem_below_radix, r_state == rde_pkg::ST_DIV, r_rem < r_radix)
    `RDE_CHECK(a_read_in_emit, r_rd_pend, r_state == rde_pkg::ST_EMIT)
    `RDE_CHECK(a_count_bound, 1'b1, r_count <= rde_pkg::COUNT_W'(rde_pkg::STORE_DEPTH))
    `RDE_CHECK(a_count_on_last, o_valid, o_item.last_digit == (o_item.digit_count != '0))

endmodule

// ----- rtl/radix_digit_emitter_top.sv -----
// Flow: an item is queued at acceptance and popped the next cycle when the back end is
// idle; division yields one digit per pass over the value chunks, and the stored digits
// are then read out in reverse. Throughput: one digit per cycle on output while i_stall
// is low; the next item is popped after the last digit is loaded; up to 64 digits per item.
// Reset: synchronous active low; clears queue, state machine, counts and output valid.
// The digit store is not cleared and needs no clearing pass.
module radix_digit_emitter_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  rde_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output rde_pkg::t_out_item o_item
);

    rde_pkg::t_job job;
    logic          job_valid;
    logic          job_pop;

    // Accept and classify items
    rde_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_job       (job),
        .o_job_valid (job_valid),
        .i_job_pop   (job_pop)
    );

    // Convert and emit digits
    rde_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_job_valid (job_valid),
        .o_job_pop   (job_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item)
    );

endmodule

// ----- tb/sv/tb_radix_digit_emitter_top.sv -----
// Self-checking testbench for the radix digit emitter: corner numbers, random numbers, back-pressure.
module tb_radix_digit_emitter_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 1000;
    localparam int MAX_DIGITS     = 64;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    rde_pkg::t_in_item  i_item  = '0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    rde_pkg::t_out_item o_item;

    // Digits still owed by the block, oldest first
    rde_pkg::t_out_item expected_digits [$];

    int error_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int idle_cycles   = 0;
    int holdoff_seq   = 0;
    int holdoff_seen  = 0;
    int holdoff_left  = 0;

    radix_digit_emitter_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Convert one number to its digit items and queue them, most significant first
    function automatic void queue_expected_digits(input rde_pkg::t_in_item item);
        logic [63:0]        rest;
        logic [63:0]        base;
        logic [3:0]         digits [MAX_DIGITS];
        logic               upper;
        string              glyphs;
        rde_pkg::t_out_item digit;
        int                 n;
        rest  = item.number;
        base  = 64'(item.radix);
        upper = item.upper_case;
        n     = 0;
        // saturate the base into 2..16
        if (base < 64'd2) begin
            base = 64'd2;
        end
        if (base > 64'd16) begin
            base = 64'd16;
        end
        // signed mode: take the magnitude, letters always upper case
        if (item.signed_mode) begin
            upper = 1'b1;
            if (rest[63]) begin
                rest = ~rest + 64'd1;
            end
        end
        glyphs = upper ? "0123456789ABCDEF" : "0123456789abcdef";
        // peel digits least significant first
        do begin
            digits[n] = 4'(rest % base);
            rest      = rest / base;
            n++;
        end while (rest != 64'd0 && n < MAX_DIGITS);
        for (int k = 0; k < n; k++) begin
            digit.digit_char  = 7'(glyphs[digits[n - 1 - k]]);
            digit.last_digit  = (k == n - 1);
            digit.digit_count = (k == n - 1) ? 7'(n) : 7'd0;
            expected_digits.push_back(digit);
        end
    endfunction

    function automatic rde_pkg::t_in_item number_item(input logic [63:0] number,
                                                      input logic [4:0] radix,
                                                      input logic signed_mode,
                                                      input logic upper_case);
        rde_pkg::t_in_item item;
        item.number      = number;
        item.radix       = radix;
        item.signed_mode = signed_mode;
        item.upper_case  = upper_case;
        return item;
    endfunction

    // Mostly short numbers, some full width, small negatives in signed mode
    function automatic rde_pkg::t_in_item random_number_item();
        rde_pkg::t_in_item item;
        logic [63:0]       mag;
        mag = {$urandom, $urandom};
        if ($urandom_range(4) != 0) begin
            mag = mag >> $urandom_range(63, 16);
        end
        item.signed_mode = 1'($urandom_range(1));
        item.upper_case  = 1'($urandom_range(1));
        if ($urandom_range(7) == 0) begin
            item.radix = 5'($urandom_range(31));
        end else begin
            item.radix = 5'($urandom_range(16, 2));
        end
        if (item.signed_mode && $urandom_range(1) == 1) begin
            item.number = ~mag + 64'd1;
        end else begin
            item.number = mag;
        end
        return item;
    endfunction

    // Offer one item, with optional idle cycles first; hold it until accepted
    task automatic offer_number(input rde_pkg::t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= item;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        queue_expected_digits(item);
    endtask

    // Stop sending and wait until every owed digit has come out
    task automatic wait_all_digits();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (expected_digits.size() != 0);
    endtask

    task automatic test_directed_corners();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        offer_number(number_item(64'd0, 5'd10, 1'b0, 1'b0));
        offer_number(number_item(64'd0, 5'd16, 1'b1, 1'b0));
        offer_number(number_item(64'd1, 5'd2, 1'b0, 1'b0));
        offer_number(number_item('1, 5'd2, 1'b0, 1'b0));
        offer_number(number_item('1, 5'd16, 1'b0, 1'b0));
        offer_number(number_item('1, 5'd16, 1'b0, 1'b1));
        offer_number(number_item('1, 5'd10, 1'b1, 1'b0));
        // most negative value: magnitude 2^63
        offer_number(number_item(64'h8000_0000_0000_0000, 5'd10, 1'b1, 1'b0));
        offer_number(number_item(64'h8000_0000_0000_0000, 5'd2, 1'b1, 1'b1));
        offer_number(number_item(64'h8000_0000_0000_0000, 5'd16, 1'b0, 1'b0));
        offer_number(number_item(64'h7FFF_FFFF_FFFF_FFFF, 5'd10, 1'b1, 1'b0));
        // signed mode forces upper case letters
        offer_number(number_item(64'hFFFF_FFFF_FFFF_FFF5, 5'd16, 1'b1, 1'b0));
        offer_number(number_item(64'hFEDC_BA98_7654_3210, 5'd16, 1'b0, 1'b0));
        offer_number(number_item(64'hFEDC_BA98_7654_3210, 5'd16, 1'b0, 1'b1));
        offer_number(number_item(64'hFEDC_BA98_7654_3210, 5'd8, 1'b0, 1'b0));
        offer_number(number_item(64'hFEDC_BA98_7654_3210, 5'd3, 1'b0, 1'b1));
        // radix below two saturates to binary, above sixteen to hex
        offer_number(number_item(64'd255, 5'd0, 1'b0, 1'b0));
        offer_number(number_item(64'd255, 5'd1, 1'b0, 1'b1));
        offer_number(number_item(64'd255, 5'd17, 1'b0, 1'b0));
        offer_number(number_item(64'd255, 5'd31, 1'b0, 1'b1));
        offer_number(number_item(64'd12345, 5'd10, 1'b1, 1'b1));
        offer_number(number_item(64'hABCD, 5'd12, 1'b0, 1'b0));
        offer_number(number_item(64'h0123_4567_89AB_CDEF, 5'd13, 1'b0, 1'b1));
        offer_number(number_item(64'd1000000, 5'd7, 1'b1, 1'b0));
        offer_number(number_item(64'd14, 5'd15, 1'b0, 1'b1));
        wait_all_digits();
    endtask

    task automatic test_random_numbers(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) begin
            offer_number(random_number_item());
        end
        wait_all_digits();
    endtask

    // Hold off the output so the block fills and stalls its input
    task automatic test_output_holdoff();
        send_idle_pct = 0;
        recv_idle_pct = 20;
        holdoff_seq <= holdoff_seq + 1;
        repeat (24) begin
            offer_number(random_number_item());
        end
        wait_all_digits();
    endtask

    // Output receiver: random stall, or a long hold-off on request
    always @(posedge i_clk) begin
        if (holdoff_seen != holdoff_seq) begin
            holdoff_seen <= holdoff_seq;
            holdoff_left <= HOLDOFF_CYCLES;
            i_stall      <= 1'b1;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
            i_stall      <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Compare each accepted digit with the oldest owed one
    always @(posedge i_clk) begin : check_digits
        rde_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_digits.size() == 0) begin
                error_count++;
                $display("%0t: unexpected digit, expected none, got char %h last %b count %0d",
                         $time, o_item.digit_char, o_item.last_digit, o_item.digit_count);
            end else begin
                want = expected_digits.pop_front();
                if (o_item.digit_char !== want.digit_char) begin
                    error_count++;
                    $display("%0t: digit_char expected %h got %h",
                             $time, want.digit_char, o_item.digit_char);
                end
                if (o_item.last_digit !== want.last_digit) begin
                    error_count++;
                    $display("%0t: last_digit expected %b got %b",
                             $time, want.last_digit, o_item.last_digit);
                end
                if (o_item.digit_count !== want.digit_count) begin
                    error_count++;
                    $display("%0t: digit_count expected %0d got %0d",
                             $time, want.digit_count, o_item.digit_count);
                end
            end
        end
    end

    // Watchdog: end the run when no item moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d digits still owed",
                     $time, idle_cycles, expected_digits.size());
            $display("tb_radix_digit_emitter_top: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_corners();
        test_random_numbers(120, 7, 73);
        test_output_holdoff();
        test_random_numbers(110, 73, 7);
        test_random_numbers(110, 0, 0);
        // let any stray digit surface before the verdict
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_radix_digit_emitter_top: PASS");
        end else begin
            $display("tb_radix_digit_emitter_top: FAIL");
        end
        $finish;
    end

endmodule

// ----- radix_digit_emitter_top.f -----
+incdir+rtl
rtl/rde_pkg.sv
rtl/rde_front.sv
rtl/rde_back.sv
rtl/radix_digit_emitter_top.sv
tb/sv/tb_radix_digit_emitter_top.sv
